### hw/rtl/pgd_pkg.sv
// Shared constants and types for the pheromone grid diffusion unit.
`timescale 1ns / 1ps
package pgd_pkg;
    localparam int GRID_MAX   = 128;
    localparam int COORD_W    = $clog2(GRID_MAX);
    localparam int ADDR_W     = 2 * COORD_W;
    localparam int DEPTH      = GRID_MAX * GRID_MAX;
    localparam int LEVEL_W    = 32;
    localparam int EXT_W      = COORD_W + 1;

    localparam logic [1:0] MODE_DEPOSIT = 2'd0;
    localparam logic [1:0] MODE_SWEEP   = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;
    localparam logic [1:0] MODE_QUERY   = 2'd3;

    localparam logic [1:0] REG_EXTENT = 2'd0;
    localparam logic [1:0] REG_KEEP   = 2'd1;
    localparam logic [1:0] REG_SPREAD = 2'd2;
    localparam logic [1:0] REG_CUTOFF = 2'd3;

    localparam logic [LEVEL_W-1:0] ONE_Q824  = 32'h0100_0000;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               found;
        logic [1:0]         row_step;
        logic [1:0]         col_step;
        logic               saturated;
    } result_t;
endpackage

### hw/rtl/pgd_ram.sv
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
module pgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### hw/rtl/pgd_engine.sv
// Sequencer that reads grid cells for in-area operations and updates and writes them back for deposits and sweeps.
`timescale 1ns / 1ps
module pgd_engine import pgd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [1:0]         mode,
    input  logic [COORD_W-1:0] row,
    input  logic [COORD_W-1:0] col,
    input  logic [EXT_W-1:0]   extent,
    input  logic [15:0]        keep_gain,
    input  logic [15:0]        spread_gain,
    input  logic [15:0]        cutoff_level,
    output logic               busy,
    output logic               done,
    output result_t            result
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLEAR = 4'd1;
    localparam logic [3:0] ST_RD    = 4'd2;
    localparam logic [3:0] ST_ACC   = 4'd3;
    localparam logic [3:0] ST_MUL   = 4'd4;
    localparam logic [3:0] ST_WB    = 4'd5;
    localparam logic [3:0] ST_DONE  = 4'd6;

    logic [3:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic [1:0]         mode_reg, mode_next;
    logic [COORD_W-1:0] r_reg, r_next, c_reg, c_next;
    logic [3:0]         k_reg, k_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [3:0]         kd_reg, kd_next;
    logic [LEVEL_W+3:0] sum_reg, sum_next;
    logic [LEVEL_W-1:0] own_reg, own_next, best_reg, best_next;
    logic [47:0]        pk_reg, pk_next;
    logic [51:0]        ps_reg, ps_next;
    logic               sat_reg, sat_next, found_reg, found_next;
    logic [1:0]         rs_reg, rs_next, cs_reg, cs_next;
    result_t            res_reg, res_next;
    logic               done_reg, done_next;

    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [LEVEL_W-1:0] wdata, rdata;

    pgd_ram #(.WIDTH(LEVEL_W), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    // Row and column offsets of neighbour k, packed as {row, column}, three bits each.
    function automatic logic [5:0] nb_offset(input logic [3:0] k);
        case (k)
            4'd0:    nb_offset = 6'b111_111;
            4'd1:    nb_offset = 6'b111_000;
            4'd2:    nb_offset = 6'b111_001;
            4'd3:    nb_offset = 6'b000_111;
            4'd5:    nb_offset = 6'b000_001;
            4'd6:    nb_offset = 6'b001_111;
            4'd7:    nb_offset = 6'b001_000;
            4'd8:    nb_offset = 6'b001_001;
            default: nb_offset = 6'b000_000;
        endcase
    endfunction

    // Neighbour k (0..8, 4 is the center) of (r_reg, c_reg).
    logic signed [2:0] dr, dc;
    logic [EXT_W:0]    nr, nc;
    logic              k_ok;
    always_comb begin
        {dr, dc} = nb_offset(k_reg);
        nr = (EXT_W+1)'({1'b0, r_reg}) + (EXT_W+1)'(signed'(dr));
        nc = (EXT_W+1)'({1'b0, c_reg}) + (EXT_W+1)'(signed'(dc));
        k_ok = !nr[EXT_W] && !nc[EXT_W] && (nr < (EXT_W+1)'(extent))
               && (nc < (EXT_W+1)'(extent));
    end

    logic signed [2:0] kdr, kdc;
    logic [47:0] sum_ext;
    logic [52:0] acc;
    logic [LEVEL_W:0] dep;
    always_comb begin
        {kdr, kdc} = nb_offset(kd_reg);
        sum_ext = 48'(sum_reg);
        acc = 53'(pk_reg) + 53'(ps_reg);
        dep = {1'b0, own_reg} + {1'b0, ONE_Q824};
    end

    logic [LEVEL_W-1:0] upd;
    logic               upd_sat;
    always_comb begin
        upd_sat = |acc[52:48];
        upd = upd_sat ? LEVEL_MAX : acc[47:16];
        if (upd < LEVEL_W'(cutoff_level)) upd = '0;
    end

    always_comb begin
        state_next = state_reg; clr_next = clr_reg; mode_next = mode_reg;
        r_next = r_reg; c_next = c_reg; k_next = k_reg;
        rd_pend_next = 1'b0; kd_next = k_reg;
        sum_next = sum_reg; own_next = own_reg; best_next = best_reg;
        pk_next = pk_reg; ps_next = ps_reg; sat_next = sat_reg;
        found_next = found_reg; rs_next = rs_reg; cs_next = cs_reg;
        res_next = res_reg; done_next = 1'b0;
        we = 1'b0; addr = {nr[COORD_W-1:0], nc[COORD_W-1:0]}; wdata = '0;
        case (state_reg)
            ST_CLEAR: begin
                we = 1'b1; addr = clr_reg; clr_next = clr_reg + 1'b1;
                if (&clr_reg) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    mode_next = mode; k_next = '0;
                    sum_next = '0; best_next = '0; sat_next = 1'b0;
                    found_next = 1'b0; rs_next = '0; cs_next = '0;
                    if (mode == MODE_SWEEP) begin
                        r_next = '0; c_next = '0;
                        if (extent == '0) begin
                            res_next = '0; state_next = ST_DONE;
                        end else begin
                            state_next = ST_RD;
                        end
                    end else begin
                        r_next = row; c_next = col;
                        if (EXT_W'(row) >= extent || EXT_W'(col) >= extent) begin
                            res_next = '0; state_next = ST_DONE;
                        end else begin
                            state_next = ST_RD;
                        end
                    end
                end
            end
            ST_RD: begin
                // Read k = 0..8 (sweep, query) or k = 4 alone, one per cycle; data returns the next cycle.
                rd_pend_next = k_ok;
                if (mode_reg == MODE_DEPOSIT || mode_reg == MODE_READ) begin
                    k_next = 4'd4; kd_next = 4'd4; rd_pend_next = 1'b1;
                    addr = {r_reg, c_reg};
                    if (k_reg == 4'd4) begin
                        rd_pend_next = 1'b0; state_next = ST_ACC;
                    end
                end else begin
                    k_next = k_reg + 4'd1;
                    if (k_reg == 4'd8) state_next = ST_ACC;
                end
                if (rd_pend_reg) begin
                    if (kd_reg == 4'd4) own_next = rdata;
                    else sum_next = sum_reg + (LEVEL_W+4)'(rdata);
                    if (mode_reg == MODE_QUERY && kd_reg != 4'd4 && rdata > best_reg) begin
                        best_next = rdata; found_next = 1'b1;
                        rs_next = kdr[1:0]; cs_next = kdc[1:0];
                    end
                end
            end
            ST_ACC: begin
                if (rd_pend_reg) begin
                    if (kd_reg == 4'd4) own_next = rdata;
                    else sum_next = sum_reg + (LEVEL_W+4)'(rdata);
                    if (mode_reg == MODE_QUERY && kd_reg != 4'd4 && rdata > best_reg) begin
                        best_next = rdata; found_next = 1'b1;
                        rs_next = kdr[1:0]; cs_next = kdc[1:0];
                    end
                end
                state_next = (mode_reg == MODE_SWEEP) ? ST_MUL : ST_WB;
            end
            ST_MUL: begin
                pk_next = 48'(keep_gain) * 48'(own_reg);
                ps_next = 52'(spread_gain) * 52'(sum_ext[35:0]);
                state_next = ST_WB;
            end
            ST_WB: begin
                addr = {r_reg, c_reg};
                res_next = '0;
                case (mode_reg)
                    MODE_SWEEP: begin
                        we = 1'b1; wdata = upd;
                        if (upd_sat) sat_next = 1'b1;
                        sum_next = '0; k_next = '0;
                        if (EXT_W'(c_reg) + 1'b1 == extent) begin
                            c_next = '0;
                            if (EXT_W'(r_reg) + 1'b1 == extent) begin
                                res_next.saturated = sat_reg | upd_sat;
                                state_next = ST_DONE;
                            end else begin
                                r_next = r_reg + 1'b1; state_next = ST_RD;
                            end
                        end else begin
                            c_next = c_reg + 1'b1; state_next = ST_RD;
                        end
                    end
                    MODE_DEPOSIT: begin
                        we = 1'b1;
                        wdata = dep[LEVEL_W] ? LEVEL_MAX : dep[LEVEL_W-1:0];
                        res_next.level = wdata;
                        res_next.saturated = dep[LEVEL_W];
                        state_next = ST_DONE;
                    end
                    MODE_QUERY: begin
                        res_next.level = own_reg; res_next.found = found_reg;
                        res_next.row_step = rs_reg; res_next.col_step = cs_reg;
                        state_next = ST_DONE;
                    end
                    default: begin
                        res_next.level = own_reg; state_next = ST_DONE;
                    end
                endcase
            end
            ST_DONE: begin
                done_next = 1'b1; state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR; clr_reg <= '0; done_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next; clr_reg <= clr_next; done_reg <= done_next;
            rd_pend_reg <= rd_pend_next;
        end
        mode_reg <= mode_next; r_reg <= r_next; c_reg <= c_next; k_reg <= k_next;
        kd_reg <= kd_next; sum_reg <= sum_next; own_reg <= own_next;
        best_reg <= best_next; pk_reg <= pk_next; ps_reg <= ps_next;
        sat_reg <= sat_next; found_reg <= found_next; rs_reg <= rs_next;
        cs_reg <= cs_next; res_reg <= res_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;
endmodule

### hw/rtl/pheromone_grid_diffusion_unit.sv
// Top level of the pheromone grid diffusion unit.
// Deposit and read fetch the addressed cell alone; a query reads the cell and its eight neighbours, one read a cycle.
// A sweep steps through each cell of the active area in turn: nine reads, accumulate, multiply, write back.
// One item is in work at a time; the next can be taken in the cycle after the result transaction.
// After reset a clearing pass zeroes all 16384 cells of the grid before items are taken.
// Registers return to 100, 32768, 3277 and 17 on the synchronous active-low reset.
`timescale 1ns / 1ps
module pheromone_grid_diffusion_unit import pgd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // mode[1:0], cell_row[8:2], cell_col[15:9]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // level[31:0], found[32], row_step[34:33],
                                   // col_step[36:35], saturated[37], zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    logic [7:0]  ext_reg;
    logic [15:0] keep_reg, spread_reg, cut_reg;
    logic        mval_reg;
    result_t     mres_reg;
    logic        busy, done, start;
    result_t     res;
    logic [EXT_W-1:0] extent;

    assign extent = (ext_reg > 8'(GRID_MAX)) ? EXT_W'(GRID_MAX) : EXT_W'(ext_reg);
    assign s_tready = !busy && !mval_reg && !done;
    assign start = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    pgd_engine u_engine (
        .aclk(aclk), .aresetn(aresetn), .start(start), .mode(s_tdata[1:0]),
        .row(s_tdata[8:2]), .col(s_tdata[15:9]), .extent(extent),
        .keep_gain(keep_reg), .spread_gain(spread_reg), .cutoff_level(cut_reg),
        .busy(busy), .done(done), .result(res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_reg <= 8'd100; keep_reg <= 16'd32768; spread_reg <= 16'd3277;
            cut_reg <= 16'd17; mval_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_EXTENT: ext_reg <= cfg_data[7:0];
                    REG_KEEP:   keep_reg <= cfg_data;
                    REG_SPREAD: spread_reg <= cfg_data;
                    REG_CUTOFF: cut_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (done) mval_reg <= 1'b1;
            else if (m_tready) mval_reg <= 1'b0;
        end
        if (done) mres_reg <= res;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata = {2'b00, mres_reg.saturated, mres_reg.col_step, mres_reg.row_step,
                      mres_reg.found, mres_reg.level};
endmodule

### hw/rtl/pgd_checker.sv
// Port-level checker for the pheromone grid diffusion unit, bound to the top level.
`timescale 1ns / 1ps
module pgd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_noacc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");
    a_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid)
        else $error("result appeared too early");
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[32] |-> m_tdata[36:33] == 4'd0)
        else $error("steps set without a found neighbour");
endmodule

bind pheromone_grid_diffusion_unit pgd_checker u_pgd_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

### sim/tb_pheromone_grid_diffusion_unit.sv
// Self-checking testbench for the pheromone grid diffusion unit.
`timescale 1ns / 1ps
module tb_pheromone_grid_diffusion_unit;
    import pgd_pkg::*;

    typedef struct {
        logic [31:0] level;
        logic        found;
        logic [1:0]  row_step;
        logic [1:0]  col_step;
        logic        saturated;
    } cell_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    pheromone_grid_diffusion_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Model of the grid and its registers.
    bit [31:0] grid_levels [DEPTH];
    bit [7:0]  extent_reg = 8'd100;
    bit [15:0] keep_reg   = 16'd32768;
    bit [15:0] spread_reg = 16'd3277;
    bit [15:0] cutoff_reg = 16'd17;

    logic [15:0]  pending_ops [$];
    cell_result_t expected_results [$];
    int           error_count = 0;
    int           send_gap = 0;
    int           recv_gap = 0;
    int           recv_hold = 0;
    bit           idling_on = 1'b1;
    logic         s_fire = 1'b0;
    int           quiet_cycles = 0;

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic logic [15:0] pack_op(logic [1:0] mode, int row, int col);
        return {col[6:0], row[6:0], mode};
    endfunction

    task automatic add_op(logic [1:0] mode, int row, int col);
        pending_ops.insert(pending_ops.size(), pack_op(mode, row, col));
    endtask

    function automatic cell_result_t predict_cell_op(logic [1:0] mode, int row, int col);
        cell_result_t res;
        int n;
        int nr;
        int nc;
        longint unsigned neigh_sum;
        longint unsigned acc;
        bit [31:0] best;
        bit [31:0] v;
        res = '{32'd0, 1'b0, 2'd0, 2'd0, 1'b0};
        n = (extent_reg > GRID_MAX) ? GRID_MAX : int'(extent_reg);
        if (mode == MODE_SWEEP) begin
            for (int r = 0; r < n; r++) begin
                for (int c = 0; c < n; c++) begin
                    neigh_sum = 0;
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            nr = r + dr;
                            nc = c + dc;
                            if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < n && nc < n)
                                neigh_sum += grid_levels[nr * GRID_MAX + nc];
                        end
                    end
                    acc = (longint'(keep_reg) * grid_levels[r * GRID_MAX + c]
                           + longint'(spread_reg) * neigh_sum) >> 16;
                    if (acc > 64'hFFFF_FFFF) begin
                        acc = 64'hFFFF_FFFF;
                        res.saturated = 1'b1;
                    end
                    if (acc < cutoff_reg) acc = 0;
                    grid_levels[r * GRID_MAX + c] = acc[31:0];
                end
            end
        end else if (row < n && col < n) begin
            if (mode == MODE_DEPOSIT) begin
                v = grid_levels[row * GRID_MAX + col];
                if (v > LEVEL_MAX - ONE_Q824) begin
                    v = LEVEL_MAX;
                    res.saturated = 1'b1;
                end else begin
                    v += ONE_Q824;
                end
                grid_levels[row * GRID_MAX + col] = v;
            end else if (mode == MODE_QUERY) begin
                best = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        nr = row + dr;
                        nc = col + dc;
                        if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < n && nc < n)
                        begin
                            v = grid_levels[nr * GRID_MAX + nc];
                            if (v > best) begin
                                best = v;
                                res.found = 1'b1;
                                res.row_step = 2'(dr);
                                res.col_step = 2'(dc);
                            end
                        end
                    end
                end
            end
            res.level = grid_levels[row * GRID_MAX + col];
        end
        return res;
    endfunction

    // Driver for the input stream.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (!s_tvalid || s_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                s_tdata  <= pending_ops.pop_front();
                s_tvalid <= 1'b1;
                if (idling_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 16);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver with random and forced stalls.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold--;
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (idling_on && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 16);
        end
    end

    // Monitor: predicts on each accepted input and checks each result.
    always @(posedge aclk) begin
        cell_result_t exp_res;
        cell_result_t got;
        s_fire <= s_tvalid && s_tready && aresetn;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_EXTENT: extent_reg = cfg_data[7:0];
                    REG_KEEP:   keep_reg   = cfg_data;
                    REG_SPREAD: spread_reg = cfg_data;
                    REG_CUTOFF: cutoff_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_results.insert(expected_results.size(),
                    predict_cell_op(s_tdata[1:0], int'(s_tdata[8:2]), int'(s_tdata[15:9])));
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[31:0], m_tdata[32], m_tdata[34:33], m_tdata[36:35],
                        m_tdata[37]};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transaction, level %h", $time, got.level);
                    error_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got.level !== exp_res.level) begin
                        $display("%0t: level expected %h actual %h", $time, exp_res.level,
                                 got.level);
                        error_count++;
                    end
                    if (got.found !== exp_res.found) begin
                        $display("%0t: found expected %b actual %b", $time, exp_res.found,
                                 got.found);
                        error_count++;
                    end
                    if (got.row_step !== exp_res.row_step) begin
                        $display("%0t: row_step expected %b actual %b", $time,
                                 exp_res.row_step, got.row_step);
                        error_count++;
                    end
                    if (got.col_step !== exp_res.col_step) begin
                        $display("%0t: col_step expected %b actual %b", $time,
                                 exp_res.col_step, got.col_step);
                        error_count++;
                    end
                    if (got.saturated !== exp_res.saturated) begin
                        $display("%0t: saturated expected %b actual %b", $time,
                                 exp_res.saturated, got.saturated);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= 700000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_ops.size() > 0 || s_tvalid || expected_results.size() > 0);
        repeat (30) @(posedge aclk);
    endtask

    task automatic queue_random_ops(int count, int max_rc, int sweep_pct);
        logic [1:0] mode;
        int pick;
        int rc_lim;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < sweep_pct) mode = MODE_SWEEP;
            else if (pick < 55) mode = MODE_DEPOSIT;
            else if (pick < 75) mode = MODE_READ;
            else mode = MODE_QUERY;
            rc_lim = ($urandom_range(0, 99) < 15) ? 127 : max_rc;
            add_op(mode, $urandom_range(0, rc_lim), $urandom_range(0, rc_lim));
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: deposits, reads, queries, ties and out-of-area addresses.
        add_op(MODE_DEPOSIT, 0, 0);
        add_op(MODE_DEPOSIT, 0, 0);
        add_op(MODE_DEPOSIT, 0, 1);
        add_op(MODE_DEPOSIT, 99, 99);
        add_op(MODE_READ, 0, 0);
        add_op(MODE_QUERY, 1, 1);
        add_op(MODE_QUERY, 0, 0);
        add_op(MODE_DEPOSIT, 1, 0);
        add_op(MODE_QUERY, 1, 1);
        add_op(MODE_QUERY, 50, 50);
        add_op(MODE_DEPOSIT, 100, 3);
        add_op(MODE_READ, 3, 100);
        add_op(MODE_QUERY, 127, 127);
        add_op(MODE_READ, 99, 99);
        wait_drained();

        // Full gains drive the levels into saturation.
        write_reg(REG_EXTENT, 16'd4);
        write_reg(REG_KEEP, 16'hFFFF);
        write_reg(REG_SPREAD, 16'hFFFF);
        write_reg(REG_CUTOFF, 16'd0);
        add_op(MODE_DEPOSIT, 1, 1);
        repeat (5) add_op(MODE_SWEEP, 0, 0);
        add_op(MODE_DEPOSIT, 2, 2);
        add_op(MODE_READ, 3, 3);
        add_op(MODE_QUERY, 3, 0);
        queue_random_ops(40, 5, 10);
        wait_drained();

        // Zero gains with the highest cutoff clear the area.
        write_reg(REG_EXTENT, 16'd2);
        write_reg(REG_KEEP, 16'd0);
        write_reg(REG_SPREAD, 16'd0);
        write_reg(REG_CUTOFF, 16'hFFFF);
        add_op(MODE_SWEEP, 0, 0);
        add_op(MODE_READ, 0, 0);
        add_op(MODE_DEPOSIT, 1, 1);
        add_op(MODE_QUERY, 0, 0);
        wait_drained();

        // A single cell has no neighbours; an extent of zero has no cells.
        write_reg(REG_EXTENT, 16'd1);
        write_reg(REG_KEEP, 16'd40000);
        write_reg(REG_CUTOFF, 16'd5);
        add_op(MODE_DEPOSIT, 0, 0);
        add_op(MODE_QUERY, 0, 0);
        add_op(MODE_SWEEP, 0, 0);
        add_op(MODE_READ, 0, 0);
        add_op(MODE_DEPOSIT, 0, 1);
        wait_drained();
        write_reg(REG_EXTENT, 16'd0);
        add_op(MODE_DEPOSIT, 0, 0);
        add_op(MODE_SWEEP, 0, 0);
        add_op(MODE_READ, 0, 0);
        wait_drained();

        // An extent above the grid size is clipped to the full grid.
        write_reg(REG_EXTENT, 16'd255);
        write_reg(REG_KEEP, 16'd32768);
        write_reg(REG_SPREAD, 16'd3277);
        write_reg(REG_CUTOFF, 16'd17);
        add_op(MODE_DEPOSIT, 127, 127);
        add_op(MODE_DEPOSIT, 127, 0);
        add_op(MODE_SWEEP, 0, 0);
        add_op(MODE_QUERY, 127, 126);
        add_op(MODE_READ, 127, 127);
        wait_drained();

        // The receiver stalls for a long stretch while items keep coming.
        @(posedge aclk);
        recv_hold = 400;
        queue_random_ops(40, 127, 0);
        wait_drained();

        write_reg(REG_EXTENT, 16'd8);
        write_reg(REG_KEEP, 16'($urandom_range(0, 65535)));
        write_reg(REG_SPREAD, 16'($urandom_range(0, 16000)));
        write_reg(REG_CUTOFF, 16'($urandom_range(0, 4000)));
        queue_random_ops(120, 9, 8);
        wait_drained();
        queue_random_ops(130, 9, 8);
        wait_drained();

        // The closing stretch runs without idling on either side.
        idling_on = 1'b0;
        write_reg(REG_EXTENT, 16'd128);
        write_reg(REG_KEEP, 16'($urandom_range(0, 65535)));
        queue_random_ops(60, 127, 0);
        wait_drained();

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

### pheromone_grid_diffusion_unit.f
hw/rtl/pgd_pkg.sv
hw/rtl/pgd_ram.sv
hw/rtl/pgd_engine.sv
hw/rtl/pheromone_grid_diffusion_unit.sv
hw/rtl/pgd_checker.sv
sim/tb_pheromone_grid_diffusion_unit.sv
